@@ src/mpac_pkg.sv @@
// Shared constants and divider sideband types for the acceleration command pipeline.
`timescale 1ns / 1ps
`default_nettype none
package mpac_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_ACCEL_LIMIT = 3'd0;
   localparam logic [2:0] CSR_MIN_SPEED   = 3'd1;
   localparam logic [2:0] CSR_SPEED_LIMIT = 3'd2;
   localparam logic [2:0] CSR_DEAD_BAND   = 3'd3;
   localparam logic [2:0] CSR_SPEED_RAMP  = 3'd4;
   localparam logic [2:0] CSR_ACCEL_RAMP  = 3'd5;

   // phase codes
   localparam logic [1:0] PH_DEAD   = 2'd0;
   localparam logic [1:0] PH_DECEL  = 2'd1;
   localparam logic [1:0] PH_ACCEL  = 2'd2;
   localparam logic [1:0] PH_CRUISE = 2'd3;

   // divider geometry: quotient bits and quotient bits retired per stage
   localparam int QUO_W    = 32;
   localparam int DIV_STEP = 2;

   // sideband carried through the target speed divider
   typedef struct packed {
      logic        dead;
      logic        ramp;
      logic        e_neg;
      logic        e_zero;
      logic [31:0] v;
      logic [63:0] vsq;
      logic [64:0] lim;
   } spd_side_type;

   // sideband carried through the acceleration divider
   typedef struct packed {
      logic dead;
      logic decel;
      logic ramp;
      logic v_neg;
      logic v_zero;
      logic ve_neg;
      logic ave_gt1;
   } acc_side_type;

endpackage
`default_nettype wire

@@ src/mpac_div.sv @@
// Pipelined restoring divider with a sideband bus that travels with each quotient.
`timescale 1ns / 1ps
`default_nettype none
module mpac_div #(
   parameter int N    = mpac_pkg::QUO_W,
   parameter int STEP = mpac_pkg::DIV_STEP,
   parameter int PW   = 8
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   input  wire logic [2*N-1:0]  in_dividend,
   input  wire logic [N-1:0]    in_divisor,
   input  wire logic [PW-1:0]   in_side,
   output logic                 out_valid,
   output logic [N-1:0]         out_quotient,
   output logic [PW-1:0]        out_side
);

   localparam int NST = N / STEP;

   // the upper dividend half must already be below the divisor
   logic [NST-1:0] valid_ff;
   logic [N-1:0]   rem_ff  [NST];
   logic [N-1:0]   word_ff [NST];
   logic [N-1:0]   dvs_ff  [NST];
   logic [PW-1:0]  side_ff [NST];

   for (genvar s = 0; s < NST; s++) begin : g_stage
      logic          valid_src;
      logic [N-1:0]  rem_src, word_src, dvs_src;
      logic [PW-1:0] side_src;
      logic [N-1:0]  rem_in, word_in;

      if (s == 0) begin : g_head
         assign valid_src = in_valid;
         assign rem_src   = in_dividend[2*N-1:N];
         assign word_src  = in_dividend[N-1:0];
         assign dvs_src   = in_divisor;
         assign side_src  = in_side;
      end else begin : g_body
         assign valid_src = valid_ff[s-1];
         assign rem_src   = rem_ff[s-1];
         assign word_src  = word_ff[s-1];
         assign dvs_src   = dvs_ff[s-1];
         assign side_src  = side_ff[s-1];
      end

      always_comb begin
         logic [N:0]   trial;
         logic [N-1:0] r, w;
         r = rem_src;
         w = word_src;
         for (int k = 0; k < STEP; k++) begin
            trial = {r, w[N-1]};
            if (trial >= {1'b0, dvs_src}) begin
               r = N'(trial - {1'b0, dvs_src});
               w = {w[N-2:0], 1'b1};
            end else begin
               r = trial[N-1:0];
               w = {w[N-2:0], 1'b0};
            end
         end
         rem_in  = r;
         word_in = w;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_src;
         end
         rem_ff[s]  <= rem_in;
         word_ff[s] <= word_in;
         dvs_ff[s]  <= dvs_src;
         side_ff[s] <= side_src;
      end
   end

   assign out_valid    = valid_ff[NST-1];
   assign out_quotient = word_ff[NST-1];
   assign out_side     = side_ff[NST-1];

endmodule
`default_nettype wire

@@ src/motion_profile_accel_command.sv @@
// Top level of the trapezoidal profile acceleration command pipeline.
`timescale 1ns / 1ps
`default_nettype none
// One transaction is accepted each cycle that start is high (busy stays low:
// the pipeline never stalls, since the receiver cannot hold results off). The
// capture register loads on the start edge, and results come back on rsp_valid
// in order. Most of the registers sit in the two 16-stage radix-4 dividers that
// form the proportional target speed and the proportional acceleration; the
// remaining five stages hold the input capture, the multipliers, the velocity
// error and the phase decision.
// Configuration registers are written through csr_we/csr_index/csr_wdata and
// may only change while no transaction is in flight.
module motion_profile_accel_command (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_position_error,
   input  wire logic [31:0] req_current_velocity,
   output logic             rsp_valid,
   output logic [31:0]      rsp_accel_command,
   output logic [1:0]       rsp_phase,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [30:0] csr_wdata
);

   localparam int QW = mpac_pkg::QUO_W;

   logic [30:0] accel_limit_ff, min_speed_ff, speed_limit_ff;
   logic [30:0] dead_band_ff, speed_ramp_ff, accel_ramp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_limit_ff <= '0;
         min_speed_ff   <= '0;
         speed_limit_ff <= '0;
         dead_band_ff   <= '0;
         speed_ramp_ff  <= '0;
         accel_ramp_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            mpac_pkg::CSR_ACCEL_LIMIT: accel_limit_ff <= csr_wdata;
            mpac_pkg::CSR_MIN_SPEED:   min_speed_ff   <= csr_wdata;
            mpac_pkg::CSR_SPEED_LIMIT: speed_limit_ff <= csr_wdata;
            mpac_pkg::CSR_DEAD_BAND:   dead_band_ff   <= csr_wdata;
            mpac_pkg::CSR_SPEED_RAMP:  speed_ramp_ff  <= csr_wdata;
            mpac_pkg::CSR_ACCEL_RAMP:  accel_ramp_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // capture stage
   logic        s0_valid_ff;
   logic [31:0] s0_e_ff, s0_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= start & ~busy;
      end
      s0_e_ff <= req_position_error;
      s0_v_ff <= req_current_velocity;
   end

   // stage A: magnitudes and the three products
   logic [31:0] ae, av;
   assign ae = s0_e_ff[31] ? 32'(-s0_e_ff) : s0_e_ff;
   assign av = s0_v_ff[31] ? 32'(-s0_v_ff) : s0_v_ff;

   logic                   a_valid_ff;
   logic [61:0]            a_prod_ff;
   mpac_pkg::spd_side_type a_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= s0_valid_ff;
      end
      a_prod_ff        <= speed_limit_ff * ae[30:0];
      a_side_ff.dead   <= ae < {1'b0, dead_band_ff};
      a_side_ff.ramp   <= ae < {1'b0, speed_ramp_ff};
      a_side_ff.e_neg  <= s0_e_ff[31];
      a_side_ff.e_zero <= s0_e_ff == '0;
      a_side_ff.v      <= s0_v_ff;
      a_side_ff.vsq    <= av * av;
      a_side_ff.lim    <= {64'(ae) * 64'({1'b0, accel_limit_ff} + 32'd1), 1'b0};
   end

   logic                   d1_valid;
   logic [QW-1:0]          d1_quo;
   logic [$bits(mpac_pkg::spd_side_type)-1:0] d1_side_bits;
   mpac_pkg::spd_side_type d1_side;

   mpac_div #(
      .N    (QW),
      .STEP (mpac_pkg::DIV_STEP),
      .PW   ($bits(mpac_pkg::spd_side_type))
   ) u_spd_div (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (a_valid_ff),
      .in_dividend  ({2'b00, a_prod_ff}),
      .in_divisor   ({1'b0, speed_ramp_ff}),
      .in_side      (a_side_ff),
      .out_valid    (d1_valid),
      .out_quotient (d1_quo),
      .out_side     (d1_side_bits)
   );

   assign d1_side = d1_side_bits;

   // stage B: target speed, velocity error, braking test
   logic [30:0]        q1, ts;
   logic signed [33:0] tv, ve;

   assign q1 = d1_quo[30:0];
   always_comb begin
      if (d1_side.ramp) begin
         ts = (q1 > min_speed_ff) ? q1 : min_speed_ff;
      end else begin
         ts = speed_limit_ff;
      end
      if (d1_side.e_neg) begin
         tv = -$signed({3'b000, ts});
      end else if (d1_side.e_zero) begin
         tv = '0;
      end else begin
         tv = $signed({3'b000, ts});
      end
      ve = tv - $signed({{2{d1_side.v[31]}}, d1_side.v});
   end

   logic        b_valid_ff;
   logic [32:0] b_ave_ff;
   logic        b_ve_neg_ff, b_dead_ff, b_decel_ff, b_v_neg_ff, b_v_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= d1_valid;
      end
      b_ave_ff    <= ve[33] ? 33'(-ve) : ve[32:0];
      b_ve_neg_ff <= ve[33];
      b_dead_ff   <= d1_side.dead;
      b_decel_ff  <= {1'b0, d1_side.vsq} >= d1_side.lim;
      b_v_neg_ff  <= d1_side.v[31];
      b_v_zero_ff <= d1_side.v == '0;
   end

   // stage C: product for the acceleration ratio
   logic                   c_valid_ff;
   logic [61:0]            c_prod_ff;
   mpac_pkg::acc_side_type c_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
      end
      c_prod_ff         <= accel_limit_ff * b_ave_ff[30:0];
      c_side_ff.dead    <= b_dead_ff;
      c_side_ff.decel   <= b_decel_ff;
      c_side_ff.ramp    <= b_ave_ff < {2'b00, accel_ramp_ff};
      c_side_ff.v_neg   <= b_v_neg_ff;
      c_side_ff.v_zero  <= b_v_zero_ff;
      c_side_ff.ve_neg  <= b_ve_neg_ff;
      c_side_ff.ave_gt1 <= b_ave_ff > 33'd1;
   end

   logic                   d2_valid;
   logic [QW-1:0]          d2_quo;
   logic [$bits(mpac_pkg::acc_side_type)-1:0] d2_side_bits;
   mpac_pkg::acc_side_type d2_side;

   mpac_div #(
      .N    (QW),
      .STEP (mpac_pkg::DIV_STEP),
      .PW   ($bits(mpac_pkg::acc_side_type))
   ) u_acc_div (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (c_valid_ff),
      .in_dividend  ({2'b00, c_prod_ff}),
      .in_divisor   ({1'b0, accel_ramp_ff}),
      .in_side      (c_side_ff),
      .out_valid    (d2_valid),
      .out_quotient (d2_quo),
      .out_side     (d2_side_bits)
   );

   assign d2_side = d2_side_bits;

   // stage D: phase decision and signed command
   logic [30:0] acc;
   logic [31:0] acc_pos, acc_neg;
   logic [31:0] cmd_in;
   logic [1:0]  phase_in;

   assign acc     = d2_side.ramp ? d2_quo[30:0] : accel_limit_ff;
   assign acc_pos = {1'b0, acc};
   assign acc_neg = 32'(-acc_pos);

   always_comb begin
      if (d2_side.dead) begin
         phase_in = mpac_pkg::PH_DEAD;
         cmd_in   = '0;
      end else if (d2_side.decel) begin
         phase_in = mpac_pkg::PH_DECEL;
         if (d2_side.v_zero) begin
            cmd_in = '0;
         end else begin
            cmd_in = d2_side.v_neg ? acc_pos : acc_neg;
         end
      end else if (d2_side.ave_gt1) begin
         phase_in = mpac_pkg::PH_ACCEL;
         cmd_in   = d2_side.ve_neg ? acc_neg : acc_pos;
      end else begin
         phase_in = mpac_pkg::PH_CRUISE;
         cmd_in   = '0;
      end
   end

   logic        rsp_valid_ff;
   logic [31:0] rsp_cmd_ff;
   logic [1:0]  rsp_phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= d2_valid;
      end
      rsp_cmd_ff   <= cmd_in;
      rsp_phase_ff <= phase_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accel_command = rsp_cmd_ff;
   assign rsp_phase         = rsp_phase_ff;

`ifndef NO_ASSERTIONS
   a_dead_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_phase == mpac_pkg::PH_DEAD |-> rsp_accel_command == '0)
      else $error("dead band transaction with nonzero command");

   a_cruise_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_phase == mpac_pkg::PH_CRUISE |-> rsp_accel_command == '0)
      else $error("cruise transaction with nonzero command");

   a_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_accel_command) <= $signed({1'b0, accel_limit_ff}) &&
                     $signed(rsp_accel_command) >= -$signed({1'b0, accel_limit_ff})))
      else $error("command outside the acceleration bound");

   a_pipe_order: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |=> c_valid_ff)
      else $error("transaction dropped between velocity error and product stages");
`endif

endmodule
`default_nettype wire

@@ tb/sv/motion_profile_accel_command_checker.sv @@
// Checker: predicts acceleration commands and compares them with the block's results.
`timescale 1ns / 1ps
`default_nettype none
module motion_profile_accel_command_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [31:0] req_position_error,
   input  wire logic [31:0] req_current_velocity,
   input  wire logic        rsp_valid,
   input  wire logic [31:0] rsp_accel_command,
   input  wire logic [1:0]  rsp_phase,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [30:0] csr_wdata,
   output int               fail_count,
   output int               pending_count,
   output int               result_count
);

   typedef struct packed {
      logic [31:0] accel_command;
      logic [1:0]  phase;
   } command_type;

   logic [30:0] accel_limit, min_speed, speed_limit, dead_band, speed_ramp, accel_ramp;
   command_type expected_commands[$];

   function automatic command_type predict_command(logic signed [31:0] err,
                                                   logic signed [31:0] vel);
      command_type r;
      logic signed [63:0] e, v, tv, ve, cmd, sgn_e;
      logic [63:0] ae, av, ts, prop, acc, ave, vsq;
      logic [95:0] lim;
      e = err;
      v = vel;
      ae = (e < 0) ? -e : e;
      av = (v < 0) ? -v : v;
      if (ae < dead_band) begin
         r.accel_command = '0;
         r.phase = mpac_pkg::PH_DEAD;
         return r;
      end
      ts = speed_limit;
      if (ae < speed_ramp) begin
         prop = (64'(speed_limit) * ae) / speed_ramp;
         ts = (prop > min_speed) ? prop : 64'(min_speed);
      end
      sgn_e = (e > 0) ? 64'sd1 : ((e < 0) ? -64'sd1 : 64'sd0);
      tv = sgn_e * $signed(ts);
      ve = tv - v;
      ave = (ve < 0) ? -ve : ve;
      acc = accel_limit;
      if (ave < accel_ramp) acc = (64'(accel_limit) * ave) / accel_ramp;
      vsq = av * av;
      lim = 96'(ae) * 96'(2 * (64'(accel_limit) + 1));
      if (96'(vsq) >= lim) begin
         r.phase = mpac_pkg::PH_DECEL;
         cmd = (v > 0) ? -$signed(acc) : ((v < 0) ? $signed(acc) : 64'sd0);
      end else if (ave > 1) begin
         r.phase = mpac_pkg::PH_ACCEL;
         cmd = (ve > 0) ? $signed(acc) : -$signed(acc);
      end else begin
         r.phase = mpac_pkg::PH_CRUISE;
         cmd = 0;
      end
      r.accel_command = cmd[31:0];
      return r;
   endfunction

   always @(posedge clock) begin
      command_type got, want;
      if (reset) begin
         accel_limit <= '0; min_speed <= '0; speed_limit <= '0;
         dead_band <= '0; speed_ramp <= '0; accel_ramp <= '0;
         expected_commands.delete();
         fail_count <= 0;
         result_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               mpac_pkg::CSR_ACCEL_LIMIT: accel_limit <= csr_wdata;
               mpac_pkg::CSR_MIN_SPEED:   min_speed <= csr_wdata;
               mpac_pkg::CSR_SPEED_LIMIT: speed_limit <= csr_wdata;
               mpac_pkg::CSR_DEAD_BAND:   dead_band <= csr_wdata;
               mpac_pkg::CSR_SPEED_RAMP:  speed_ramp <= csr_wdata;
               mpac_pkg::CSR_ACCEL_RAMP:  accel_ramp <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid) begin
            got.accel_command = rsp_accel_command;
            got.phase = rsp_phase;
            result_count <= result_count + 1;
            if (expected_commands.size() == 0) begin
               if (fail_count < 10) $display("unexpected result cmd=%h phase=%0d",
                                             got.accel_command, got.phase);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_commands.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("mismatch: expected cmd=%h phase=%0d, got cmd=%h phase=%0d",
                              want.accel_command, want.phase,
                              got.accel_command, got.phase);
                  fail_count <= fail_count + 1;
               end
            end
         end
         // the user must change registers only while idle (the block does not enforce it), so the current set applies
         if (start && !busy)
            expected_commands.push_back(predict_command(req_position_error,
                                                        req_current_velocity));
      end
      pending_count <= expected_commands.size();
   end

endmodule
`default_nettype wire

@@ tb/sv/motion_profile_accel_command_tb.sv @@
// Top of the testbench: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps
`default_nettype none
module motion_profile_accel_command_tb;

   localparam int LATENCY = 37;
   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [31:0] req_position_error = '0;
   logic [31:0] req_current_velocity = '0;
   logic        rsp_valid;
   logic [31:0] rsp_accel_command;
   logic [1:0]  rsp_phase;
   logic        csr_we = 0;
   logic [2:0]  csr_index = '0;
   logic [30:0] csr_wdata = '0;
   int fail_count, pending_count, result_count;
   int cycle_count = 0;
   int issued = 0;

   always #5 clock = ~clock;

   motion_profile_accel_command DUT (.*);
   motion_profile_accel_command_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("motion_profile_accel_command verification failed");
         $finish;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [30:0] val);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
      @(negedge clock);
   endtask

   // hold off until every transaction in flight has returned
   task automatic drain();
      start <= 0;
      @(negedge clock);
      while (pending_count != 0 || start) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic send_command(logic [31:0] err, logic [31:0] vel, bit gaps);
      int wait_cycles;
      wait_cycles = gaps ? $urandom_range(0, 12) : 0;
      if (wait_cycles != 0) begin
         start <= 0;
         repeat (wait_cycles) @(negedge clock);
      end
      start <= 1;
      req_position_error <= err;
      req_current_velocity <= vel;
      @(posedge clock);
      while (busy) @(posedge clock);
      issued++;
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_value(logic [30:0] scale);
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0} ^ 32'($urandom_range(0, 3));
         2: return 32'($urandom_range(0, 2 * scale + 2)) - 32'(scale);
         3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
      endcase
   endfunction

   initial begin
      logic [30:0] scale;
      int phase_items;
      bit gaps;
      repeat (9) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // reset configuration: all zero registers
      send_command('0, '0, 0);
      send_command(32'h8000_0000, 32'h7FFF_FFFF, 0);
      drain();

      // directed: typical profile plus extremes
      write_reg(mpac_pkg::CSR_ACCEL_LIMIT, 31'h0002_0000);
      write_reg(mpac_pkg::CSR_MIN_SPEED, 31'h0000_1000);
      write_reg(mpac_pkg::CSR_SPEED_LIMIT, 31'h0004_0000);
      write_reg(mpac_pkg::CSR_DEAD_BAND, 31'h0000_0100);
      write_reg(mpac_pkg::CSR_SPEED_RAMP, 31'h0010_0000);
      write_reg(mpac_pkg::CSR_ACCEL_RAMP, 31'h0001_0000);
      write_reg(3'd7, 31'h7FFF_FFFF);
      send_command(32'h0000_0080, 32'h0001_0000, 0);
      send_command(32'h0000_0100, 32'h0, 0);
      send_command(32'h7FFF_FFFF, 32'h0, 0);
      send_command(32'h8000_0000, 32'h0, 0);
      send_command(32'h0000_1000, 32'h0004_0000, 0);
      send_command(32'hFFFF_F000, 32'hFFFC_0000, 0);
      send_command(32'h0020_0000, 32'h0004_0000, 0);
      send_command(32'h0020_0001, 32'h0003_FFFF, 0);
      send_command(32'h0000_8000, 32'h0000_1000, 0);
      send_command(32'h7FFF_FFFF, 32'h8000_0000, 0);
      send_command(32'h8000_0000, 32'h7FFF_FFFF, 0);
      drain();
      write_reg(mpac_pkg::CSR_DEAD_BAND, '0);
      send_command('0, '0, 0);
      send_command('0, 32'h0000_0005, 0);
      drain();
      write_reg(mpac_pkg::CSR_ACCEL_LIMIT, 31'h7FFF_FFFF);
      write_reg(mpac_pkg::CSR_MIN_SPEED, 31'h7FFF_FFFF);
      write_reg(mpac_pkg::CSR_SPEED_LIMIT, 31'h7FFF_FFFF);
      write_reg(mpac_pkg::CSR_SPEED_RAMP, 31'h7FFF_FFFF);
      write_reg(mpac_pkg::CSR_ACCEL_RAMP, 31'h7FFF_FFFF);
      send_command(32'h4000_0000, 32'hC000_0000, 0);
      send_command(32'h8000_0001, 32'h7FFF_FFFF, 0);
      send_command(32'h0000_0001, 32'h0000_0001, 0);
      drain();

      // random phases, each under its own register setting
      for (int ph = 0; ph < 16; ph++) begin
         scale = (ph % 4 == 0) ? 31'h7FFF_FFFF : 31'($urandom_range(0, 32'h0008_0000));
         write_reg(mpac_pkg::CSR_ACCEL_LIMIT,
                   (ph == 1) ? '0 : 31'($urandom_range(0, scale)));
         write_reg(mpac_pkg::CSR_MIN_SPEED,
                   (ph % 5 == 2) ? '0 : 31'($urandom_range(0, scale / 4)));
         write_reg(mpac_pkg::CSR_SPEED_LIMIT,
                   (ph == 3) ? 31'h7FFF_FFFF : 31'($urandom_range(0, scale)));
         write_reg(mpac_pkg::CSR_DEAD_BAND,
                   (ph % 3 == 0) ? '0 : 31'($urandom_range(0, scale / 64)));
         write_reg(mpac_pkg::CSR_SPEED_RAMP,
                   (ph % 4 == 1) ? '0 : 31'($urandom_range(0, scale)));
         write_reg(mpac_pkg::CSR_ACCEL_RAMP,
                   (ph % 4 == 2) ? '0 : 31'($urandom_range(0, scale)));
         gaps = (ph % 3 != 1);
         phase_items = 80;
         for (int k = 0; k < phase_items; k++)
            send_command(pick_value(scale), pick_value(scale), gaps && ($urandom_range(0, 1) != 0));
         drain();
      end

      drain();
      $display("covered %0d transactions and %0d results over 16 random register settings",
               issued, result_count);
      if (fail_count == 0 && pending_count == 0)
         $display("motion_profile_accel_command verification clean");
      else
         $display("motion_profile_accel_command verification failed");
      $finish;
   end

endmodule
`default_nettype wire
